FILE: hdl/crt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the countdown relay timer.
// Depends on nothing; every other file of the timer imports it.
package crt_pkg;

    // Default width of the signed encoder step counter.
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Field limits.
    localparam logic [6:0] HOUR_MAX = 7'd99;
    localparam logic [6:0] MINSEC_MAX = 7'd59;

    // Event codes carried by the opcode field.
    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SET         = 3'd1,
        OP_START       = 3'd2,
        OP_ENCODER     = 3'd3,
        OP_POWER_FAIL  = 3'd4,
        OP_RESTORE_PRE = 3'd5,
        OP_RESTORE_REM = 3'd6,
        OP_NONE        = 3'd7
    } opcode_t;

    // Operating modes of the timer.
    typedef enum logic [2:0] {
        MODE_RUN     = 3'd0,
        MODE_HOUR    = 3'd1,
        MODE_MIN     = 3'd2,
        MODE_SEC     = 3'd3,
        MODE_STANDBY = 3'd4
    } mode_t;

    // Direction decoded from one encoder transition.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } enc_dir_t;

    // Quadrature transition codes: previous A,B followed by new A,B.
    localparam logic [3:0] QUAD_UP_0 = 4'b1101;
    localparam logic [3:0] QUAD_UP_1 = 4'b0100;
    localparam logic [3:0] QUAD_UP_2 = 4'b0010;
    localparam logic [3:0] QUAD_UP_3 = 4'b1011;
    localparam logic [3:0] QUAD_DN_0 = 4'b1110;
    localparam logic [3:0] QUAD_DN_1 = 4'b0111;
    localparam logic [3:0] QUAD_DN_2 = 4'b0001;
    localparam logic [3:0] QUAD_DN_3 = 4'b1000;

    // One input item.
    typedef struct packed {
        logic [2:0] opcode;
        logic       enc_a;
        logic       enc_b;
        logic [7:0] hour_in;
        logic [7:0] minute_in;
        logic [7:0] second_in;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       relay_on;
        logic       store_remaining;
        logic       store_preset;
        logic       clear_remaining;
    } out_item_t;

    // Requests raised while handling one item.
    typedef struct packed {
        logic store_remaining;
        logic store_preset;
        logic clear_remaining;
    } req_t;

    // Decode the direction of one quadrature transition.
    function automatic enc_dir_t quad_dir(input logic [3:0] code);
        enc_dir_t dir;
        if (code == QUAD_UP_0 || code == QUAD_UP_1 || code == QUAD_UP_2
                || code == QUAD_UP_3) begin
            dir = DIR_UP;
        end else if (code == QUAD_DN_0 || code == QUAD_DN_1 || code == QUAD_DN_2
                || code == QUAD_DN_3) begin
            dir = DIR_DOWN;
        end else begin
            dir = DIR_NONE;
        end
        return dir;
    endfunction

    // A stored byte above its limit is taken as zero.
    function automatic logic [6:0] clip_byte(input logic [7:0] v, input logic [6:0] lim);
        return (v > {1'b0, lim}) ? 7'd0 : v[6:0];
    endfunction

    // Step a field up, wrapping to zero past its limit.
    function automatic logic [6:0] wrap_inc(input logic [6:0] f, input logic [6:0] lim);
        return (f >= lim) ? 7'd0 : f + 7'd1;
    endfunction

    // Step a field down, wrapping to its limit below zero.
    function automatic logic [6:0] wrap_dec(input logic [6:0] f, input logic [6:0] lim);
        return (f == 7'd0 || f > lim) ? lim : f - 7'd1;
    endfunction

endpackage

FILE: hdl/crt_in_reg.sv
`timescale 1ns / 1ps
// Input register of the countdown relay timer: holds one item until the core takes it.
// Depends on crt_pkg for the input item type.
module crt_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  crt_pkg::in_item_t s_data,
    input  logic              advance,
    output logic              item_valid,
    output crt_pkg::in_item_t item
);
    import crt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // The register can take an item when empty or when its item moves on now.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads on every accepted item.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

FILE: hdl/crt_core.sv
`timescale 1ns / 1ps
// Timer state and the single-pass event logic that computes one result per item.
// Depends on crt_pkg for types, codes and field helper functions.
module crt_core #(
    parameter int COUNT_WIDTH = crt_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  crt_pkg::in_item_t  item,
    output crt_pkg::out_item_t result
);
    import crt_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ZERO = '0;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic signed [COUNT_WIDTH-1:0] CNT_NEG_ONE = '1;

    // State registers.
    mode_t                         mode_reg, mode_next;
    logic [6:0]                    hours_reg, hours_next;
    logic [5:0]                    minutes_reg, minutes_next;
    logic [5:0]                    seconds_reg, seconds_next;
    logic [6:0]                    pre_hours_reg, pre_hours_next;
    logic [5:0]                    pre_minutes_reg, pre_minutes_next;
    logic [5:0]                    pre_seconds_reg, pre_seconds_next;
    logic                          resumed_reg, resumed_next;
    logic                          relay_reg, relay_next;
    logic                          tick_reg, tick_next;
    logic [1:0]                    pins_reg, pins_next;
    logic signed [COUNT_WIDTH-1:0] count_reg, count_next;

    logic set_clear;
    logic run_clear;

    // Next state: first the event itself, then one pass of the mode body.
    always_comb begin
        logic [1:0] now_pins;
        logic [6:0] rh;
        logic [6:0] rm;
        logic [6:0] rs;

        mode_next        = mode_reg;
        hours_next       = hours_reg;
        minutes_next     = minutes_reg;
        seconds_next     = seconds_reg;
        pre_hours_next   = pre_hours_reg;
        pre_minutes_next = pre_minutes_reg;
        pre_seconds_next = pre_seconds_reg;
        resumed_next     = resumed_reg;
        relay_next       = relay_reg;
        tick_next        = tick_reg;
        pins_next        = pins_reg;
        count_next       = count_reg;
        set_clear        = 1'b0;
        run_clear        = 1'b0;
        now_pins         = {item.enc_a, item.enc_b};
        rh               = clip_byte(item.hour_in, HOUR_MAX);
        rm               = clip_byte(item.minute_in, MINSEC_MAX);
        rs               = clip_byte(item.second_in, MINSEC_MAX);

        // Event handling.
        case (opcode_t'(item.opcode))
            OP_TICK: begin
                tick_next = 1'b1;
            end
            OP_SET: begin
                case (mode_reg)
                    MODE_RUN: begin
                        mode_next    = MODE_HOUR;
                        hours_next   = pre_hours_reg;
                        minutes_next = pre_minutes_reg;
                        seconds_next = pre_seconds_reg;
                        if (resumed_reg) begin
                            resumed_next = 1'b0;
                            set_clear    = 1'b1;
                        end
                    end
                    MODE_HOUR: mode_next = MODE_MIN;
                    MODE_MIN:  mode_next = MODE_SEC;
                    MODE_SEC: begin
                        mode_next        = MODE_STANDBY;
                        pre_hours_next   = hours_reg;
                        pre_minutes_next = minutes_reg;
                        pre_seconds_next = seconds_reg;
                    end
                    default: mode_next = MODE_HOUR;
                endcase
            end
            OP_START: begin
                if (mode_reg == MODE_STANDBY) begin
                    hours_next   = pre_hours_reg;
                    minutes_next = pre_minutes_reg;
                    seconds_next = pre_seconds_reg;
                    mode_next    = MODE_RUN;
                end
            end
            OP_ENCODER: begin
                case (quad_dir({pins_reg, now_pins}))
                    DIR_UP: begin
                        if (count_reg < CNT_MAX) begin
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    DIR_DOWN: begin
                        if (count_reg > CNT_MIN) begin
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                    default: count_next = count_reg;
                endcase
                pins_next = now_pins;
            end
            OP_RESTORE_PRE: begin
                pre_hours_next   = rh;
                pre_minutes_next = rm[5:0];
                pre_seconds_next = rs[5:0];
            end
            OP_RESTORE_REM: begin
                hours_next   = rh;
                minutes_next = rm[5:0];
                seconds_next = rs[5:0];
                if ((rh | rm | rs) != 7'd0) begin
                    mode_next    = MODE_RUN;
                    resumed_next = 1'b1;
                end else begin
                    mode_next    = MODE_STANDBY;
                    resumed_next = 1'b0;
                end
            end
            default: begin
                // Power fail and the unused code change no state here.
            end
        endcase

        // Mode body.
        case (mode_next)
            MODE_RUN: begin
                if (tick_next) begin
                    tick_next = 1'b0;
                    if (seconds_next != 6'd0) begin
                        seconds_next = seconds_next - 6'd1;
                        relay_next   = 1'b1;
                    end else if (minutes_next != 6'd0) begin
                        relay_next   = 1'b1;
                        seconds_next = 6'(MINSEC_MAX);
                        minutes_next = minutes_next - 6'd1;
                    end else if (hours_next != 7'd0) begin
                        relay_next   = 1'b1;
                        seconds_next = 6'(MINSEC_MAX);
                        minutes_next = 6'(MINSEC_MAX);
                        hours_next   = hours_next - 7'd1;
                    end else begin
                        relay_next = 1'b0;
                        if (resumed_next) begin
                            resumed_next = 1'b0;
                            mode_next    = MODE_STANDBY;
                            run_clear    = 1'b1;
                        end
                    end
                end
            end
            MODE_STANDBY: begin
                hours_next   = 7'd0;
                minutes_next = 6'd0;
                seconds_next = 6'd0;
            end
            MODE_HOUR: begin
                if (count_next > CNT_ONE) begin
                    hours_next = wrap_inc(hours_next, HOUR_MAX);
                    count_next = CNT_ZERO;
                end else if (count_next < CNT_NEG_ONE) begin
                    hours_next = wrap_dec(hours_next, HOUR_MAX);
                    count_next = CNT_ZERO;
                end
            end
            MODE_MIN: begin
                if (count_next > CNT_ONE) begin
                    minutes_next = 6'(wrap_inc({1'b0, minutes_next}, MINSEC_MAX));
                    count_next   = CNT_ZERO;
                end else if (count_next < CNT_NEG_ONE) begin
                    minutes_next = 6'(wrap_dec({1'b0, minutes_next}, MINSEC_MAX));
                    count_next   = CNT_ZERO;
                end
            end
            MODE_SEC: begin
                if (count_next > CNT_ONE) begin
                    seconds_next = 6'(wrap_inc({1'b0, seconds_next}, MINSEC_MAX));
                    count_next   = CNT_ZERO;
                end else if (count_next < CNT_NEG_ONE) begin
                    seconds_next = 6'(wrap_dec({1'b0, seconds_next}, MINSEC_MAX));
                    count_next   = CNT_ZERO;
                end
            end
            default: begin
            end
        endcase
    end

    // Result: the state after the item, plus the requests it raised.
    always_comb begin
        req_t req;
        req.store_preset    = (opcode_t'(item.opcode) == OP_SET) && (mode_reg == MODE_SEC);
        req.clear_remaining = set_clear || run_clear;
        req.store_remaining = (opcode_t'(item.opcode) == OP_POWER_FAIL)
                              && ((hours_next != 7'd0) || (minutes_next != 6'd0)
                                  || (seconds_next != 6'd0));
        result.mode            = mode_next;
        result.hours           = hours_next;
        result.minutes         = minutes_next;
        result.seconds         = seconds_next;
        result.relay_on        = relay_next;
        result.store_remaining = req.store_remaining;
        result.store_preset    = req.store_preset;
        result.clear_remaining = req.clear_remaining;
    end

    // State update, once per item handed to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_STANDBY;
            hours_reg       <= '0;
            minutes_reg     <= '0;
            seconds_reg     <= '0;
            pre_hours_reg   <= '0;
            pre_minutes_reg <= '0;
            pre_seconds_reg <= '0;
            resumed_reg     <= 1'b0;
            relay_reg       <= 1'b0;
            tick_reg        <= 1'b0;
            pins_reg        <= '0;
            count_reg       <= CNT_ZERO;
        end else if (advance) begin
            mode_reg        <= mode_next;
            hours_reg       <= hours_next;
            minutes_reg     <= minutes_next;
            seconds_reg     <= seconds_next;
            pre_hours_reg   <= pre_hours_next;
            pre_minutes_reg <= pre_minutes_next;
            pre_seconds_reg <= pre_seconds_next;
            resumed_reg     <= resumed_next;
            relay_reg       <= relay_next;
            tick_reg        <= tick_next;
            pins_reg        <= pins_next;
            count_reg       <= count_next;
        end
    end

endmodule

FILE: hdl/crt_out_reg.sv
`timescale 1ns / 1ps
// Result register of the countdown relay timer: holds one result until it is taken.
// Depends on crt_pkg for the result item type.
module crt_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  crt_pkg::out_item_t result,
    output logic               advance,
    output logic               m_valid,
    input  logic               m_ready,
    output crt_pkg::out_item_t m_data
);
    import crt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // An item moves in when one waits and the register is free or drains now.
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: hdl/countdown_relay_timer.sv
`timescale 1ns / 1ps
// Top level of the countdown relay timer: input register, event core, result register.
// Depends on crt_pkg, crt_in_reg, crt_core and crt_out_reg.
//
//  channel  ports                        payload
//  input    s_valid, s_ready, s_data     crt_pkg::in_item_t, one event per item
//  result   m_valid, m_ready, m_data     crt_pkg::out_item_t, one result per item
//
// Each item passes the input register, is handled by the combinational event
// logic and appears in the result register; the event logic is a single pass.
// A new item may be accepted every cycle while the result register is free or drains.
// aresetn is synchronous and active low and returns the timer to standby at 0:0:0.
// When m_ready is low the result holds and at most one further item waits.
module countdown_relay_timer #(
    parameter int COUNT_WIDTH = crt_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  crt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output crt_pkg::out_item_t m_data
);
    import crt_pkg::*;

    logic      advance;
    logic      item_valid;
    in_item_t  item;
    out_item_t result;

    crt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    crt_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: verif/crt_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the countdown relay timer: predicts each result from the accepted events.
// Depends on crt_pkg for the item types, modes, event codes and quadrature codes.
package crt_tb_pkg;

    import crt_pkg::*;

    // Saturation limits of the signed encoder step count.
    localparam int STEP_MAX = (1 << (COUNT_WIDTH_DEFAULT - 1)) - 1;
    localparam int STEP_MIN = -STEP_MAX - 1;

    class crt_scoreboard;

        // Predicted timer state.
        mode_t      mode;
        logic [6:0] cur_h, cur_m, cur_s;
        logic [6:0] preset_h, preset_m, preset_s;
        logic       resumed;
        logic       relay;
        logic       tick_due;
        logic [1:0] last_pins;
        int         step_count;

        out_item_t  due_results[$];
        int         errors;

        function new();
            mode       = MODE_STANDBY;
            cur_h      = '0;
            cur_m      = '0;
            cur_s      = '0;
            preset_h   = '0;
            preset_m   = '0;
            preset_s   = '0;
            resumed    = 1'b0;
            relay      = 1'b0;
            tick_due   = 1'b0;
            last_pins  = '0;
            step_count = 0;
            errors     = 0;
        endfunction

        // In a set mode, two or more counted steps move the edited field by one.
        function logic [6:0] dial_field(logic [6:0] f, logic [6:0] lim);
            logic [6:0] v;
            v = f;
            if (step_count > 1) begin
                v = (f >= lim) ? 7'd0 : f + 7'd1;
                step_count = 0;
            end else if (step_count < -1) begin
                v = (f == 7'd0 || f > lim) ? lim : f - 7'd1;
                step_count = 0;
            end
            return v;
        endfunction

        // Apply one event and the mode logic that follows it; return the result.
        function out_item_t advance_timer(in_item_t it);
            out_item_t  r;
            logic [3:0] code;
            logic       store_rem;
            logic       store_pre;
            logic       clear_req;
            store_rem = 1'b0;
            store_pre = 1'b0;
            clear_req = 1'b0;

            // Event handling.
            case (it.opcode)
                OP_TICK: tick_due = 1'b1;
                OP_SET: begin
                    if (mode == MODE_STANDBY) begin
                        mode = MODE_HOUR;
                    end else begin
                        mode = mode_t'(mode + 1);
                        if (mode == MODE_HOUR) begin
                            cur_h = preset_h;
                            cur_m = preset_m;
                            cur_s = preset_s;
                            if (resumed) begin
                                resumed   = 1'b0;
                                clear_req = 1'b1;
                            end
                        end else if (mode == MODE_STANDBY) begin
                            preset_h  = cur_h;
                            preset_m  = cur_m;
                            preset_s  = cur_s;
                            store_pre = 1'b1;
                        end
                    end
                end
                OP_START: begin
                    if (mode == MODE_STANDBY) begin
                        cur_h = preset_h;
                        cur_m = preset_m;
                        cur_s = preset_s;
                        mode  = MODE_RUN;
                    end
                end
                OP_ENCODER: begin
                    code = {last_pins, it.enc_a, it.enc_b};
                    if (code == QUAD_UP_0 || code == QUAD_UP_1 || code == QUAD_UP_2
                            || code == QUAD_UP_3) begin
                        if (step_count < STEP_MAX) step_count++;
                    end else if (code == QUAD_DN_0 || code == QUAD_DN_1 || code == QUAD_DN_2
                            || code == QUAD_DN_3) begin
                        if (step_count > STEP_MIN) step_count--;
                    end
                    last_pins = {it.enc_a, it.enc_b};
                end
                OP_RESTORE_PRE: begin
                    preset_h = (it.hour_in > HOUR_MAX) ? 7'd0 : it.hour_in[6:0];
                    preset_m = (it.minute_in > MINSEC_MAX) ? 7'd0 : it.minute_in[6:0];
                    preset_s = (it.second_in > MINSEC_MAX) ? 7'd0 : it.second_in[6:0];
                end
                OP_RESTORE_REM: begin
                    cur_h = (it.hour_in > HOUR_MAX) ? 7'd0 : it.hour_in[6:0];
                    cur_m = (it.minute_in > MINSEC_MAX) ? 7'd0 : it.minute_in[6:0];
                    cur_s = (it.second_in > MINSEC_MAX) ? 7'd0 : it.second_in[6:0];
                    if ((cur_h | cur_m | cur_s) != 7'd0) begin
                        mode    = MODE_RUN;
                        resumed = 1'b1;
                    end else begin
                        mode    = MODE_STANDBY;
                        resumed = 1'b0;
                    end
                end
                default: ;
            endcase

            // Per-mode work that runs after every event.
            case (mode)
                MODE_RUN: begin
                    if (tick_due) begin
                        tick_due = 1'b0;
                        if (cur_s != 7'd0) begin
                            cur_s = cur_s - 7'd1;
                            relay = 1'b1;
                        end else if (cur_m != 7'd0) begin
                            relay = 1'b1;
                            cur_s = MINSEC_MAX;
                            cur_m = cur_m - 7'd1;
                        end else if (cur_h != 7'd0) begin
                            relay = 1'b1;
                            cur_s = MINSEC_MAX;
                            cur_m = MINSEC_MAX;
                            cur_h = cur_h - 7'd1;
                        end else begin
                            relay = 1'b0;
                            if (resumed) begin
                                resumed   = 1'b0;
                                mode      = MODE_STANDBY;
                                clear_req = 1'b1;
                            end
                        end
                    end
                end
                MODE_STANDBY: begin
                    cur_h = '0;
                    cur_m = '0;
                    cur_s = '0;
                end
                MODE_HOUR: cur_h = dial_field(cur_h, HOUR_MAX);
                MODE_MIN:  cur_m = dial_field(cur_m, MINSEC_MAX);
                MODE_SEC:  cur_s = dial_field(cur_s, MINSEC_MAX);
                default: ;
            endcase

            // A power fail asks to save a nonzero time.
            if (it.opcode == OP_POWER_FAIL && (cur_h | cur_m | cur_s) != 7'd0) begin
                store_rem = 1'b1;
            end

            r.mode            = mode;
            r.hours           = cur_h;
            r.minutes         = cur_m[5:0];
            r.seconds         = cur_s[5:0];
            r.relay_on        = relay;
            r.store_remaining = store_rem;
            r.store_preset    = store_pre;
            r.clear_remaining = clear_req;
            return r;
        endfunction

        // Record an accepted event and the result it must produce.
        function void note_event(in_item_t it);
            due_results.push_back(advance_timer(it));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("mode", want.mode, got.mode);
            compare_field("hours", want.hours, got.hours);
            compare_field("minutes", want.minutes, got.minutes);
            compare_field("seconds", want.seconds, got.seconds);
            compare_field("relay_on", want.relay_on, got.relay_on);
            compare_field("store_remaining", want.store_remaining, got.store_remaining);
            compare_field("store_preset", want.store_preset, got.store_preset);
            compare_field("clear_remaining", want.clear_remaining, got.clear_remaining);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for countdown_relay_timer: directed events, large step counts, random traffic.
// Depends on crt_pkg, crt_tb_pkg and the timer RTL.
module tb_top;

    import crt_pkg::*;
    import crt_tb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TURN_STEPS   = 40;
    localparam int IN_BITS      = $bits(in_item_t);

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    crt_scoreboard sb;

    // Traffic shaping for the sender and the receiver, and the sender's encoder pin state.
    bit         idle_off = 1'b0;
    bit         hold_ask = 1'b0;
    logic [1:0] enc_pins = 2'b00;
    bit         enc_up   = 1'b1;

    countdown_relay_timer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("countdown_relay_timer verification failed");
        $finish;
    end

    // Next pin pair of a clean quadrature step in either direction.
    function automatic logic [1:0] next_pins(logic [1:0] p, bit up);
        logic [1:0] n;
        case (p)
            2'b00:   n = up ? 2'b10 : 2'b01;
            2'b10:   n = up ? 2'b11 : 2'b00;
            2'b11:   n = up ? 2'b01 : 2'b10;
            default: n = up ? 2'b00 : 2'b11;
        endcase
        return n;
    endfunction

    // Offer one item and hold it until accepted, then maybe leave a gap.
    task automatic send_item(input in_item_t it);
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(it);
        if (!idle_off && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic send_ev(input opcode_t op, input logic [7:0] h, input logic [7:0] m,
                           input logic [7:0] s);
        in_item_t it;
        it           = IN_BITS'($urandom);
        it.opcode    = op;
        it.hour_in   = h;
        it.minute_in = m;
        it.second_in = s;
        send_item(it);
    endtask

    // Clean quadrature steps in one direction.
    task automatic turn(input bit up, input int steps);
        in_item_t it;
        for (int i = 0; i < steps; i++) begin
            enc_pins  = next_pins(enc_pins, up);
            it        = IN_BITS'($urandom);
            it.opcode = OP_ENCODER;
            it.enc_a  = enc_pins[1];
            it.enc_b  = enc_pins[0];
            send_item(it);
        end
    endtask

    // Stop offering until every predicted result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Random event, weighted toward sessions that set, run and count down.
    function automatic in_item_t make_item();
        in_item_t it;
        int       pick;
        it   = IN_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.opcode = OP_TICK;
        else if (pick < 38) it.opcode = OP_SET;
        else if (pick < 44) it.opcode = OP_START;
        else if (pick < 74) it.opcode = OP_ENCODER;
        else if (pick < 78) it.opcode = OP_POWER_FAIL;
        else if (pick < 85) it.opcode = OP_RESTORE_PRE;
        else if (pick < 92) it.opcode = OP_RESTORE_REM;
        else if (pick < 95) it.opcode = OP_NONE;
        else                it.opcode = 3'($urandom_range(0, 7));

        if (it.opcode == OP_ENCODER) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 99) < 20) enc_up = ~enc_up;
                enc_pins = next_pins(enc_pins, enc_up);
                it.enc_a = enc_pins[1];
                it.enc_b = enc_pins[0];
            end else begin
                enc_pins = {it.enc_a, it.enc_b};
            end
        end

        // Mostly short times so that countdowns reach zero.
        if ((it.opcode == OP_RESTORE_PRE || it.opcode == OP_RESTORE_REM)
                && $urandom_range(0, 4) != 0) begin
            it.hour_in   = ($urandom_range(0, 9) == 0) ? 8'd1 : 8'd0;
            it.minute_in = 8'($urandom_range(0, 1));
            it.second_in = 8'($urandom_range(0, 9));
        end
        return it;
    endfunction

    // Result checking at each accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_ask && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!idle_off && $urandom_range(0, 99) < 20) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field limits, upward wraps in the hour and minute modes and a downward step in seconds.
        send_ev(OP_RESTORE_PRE, 8'd99, 8'd59, 8'd59);
        send_ev(OP_START, 8'd0, 8'd0, 8'd0);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        turn(1'b1, 2);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        turn(1'b1, 2);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        turn(1'b0, 2);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        // Out-of-range stored bytes read as zero.
        send_ev(OP_RESTORE_PRE, 8'd100, 8'd60, 8'd60);
        send_ev(OP_RESTORE_PRE, 8'd255, 8'd255, 8'd255);
        // A tick in standby waits for the start press.
        send_ev(OP_RESTORE_PRE, 8'd0, 8'd0, 8'd2);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_START, 8'd0, 8'd0, 8'd0);
        send_ev(OP_START, 8'd0, 8'd0, 8'd0);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_POWER_FAIL, 8'd0, 8'd0, 8'd0);
        // Resume after an outage, then abandon it with the set button.
        send_ev(OP_RESTORE_REM, 8'd0, 8'd1, 8'd0);
        send_ev(OP_POWER_FAIL, 8'd0, 8'd0, 8'd0);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        send_ev(OP_NONE, 8'd0, 8'd0, 8'd0);
        // Resumed countdown that reaches zero drops to standby.
        send_ev(OP_RESTORE_REM, 8'd0, 8'd0, 8'd1);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_TICK, 8'd0, 8'd0, 8'd0);
        send_ev(OP_RESTORE_REM, 8'd0, 8'd0, 8'd0);
        drain();

        // Build up a large step count in standby in each direction, then edit once.
        idle_off = 1'b1;
        turn(1'b1, TURN_STEPS);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        send_ev(OP_RESTORE_REM, 8'd0, 8'd0, 8'd0);
        turn(1'b0, TURN_STEPS);
        send_ev(OP_SET, 8'd0, 8'd0, 8'd0);
        send_ev(OP_RESTORE_REM, 8'd0, 8'd0, 8'd0);
        drain();
        idle_off = 1'b0;

        // Random traffic, opening with a long receiver hold-off.
        hold_ask = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 300) idle_off = 1'b1;
            if (n % 450 == 449) drain();
            send_item(make_item());
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("countdown_relay_timer verification clean");
        end else begin
            $display("countdown_relay_timer verification failed");
        end
        $finish;
    end

endmodule
